@@ hdl/vds_pkg.sv @@
// shared types and constants for the vector distance scorer
`timescale 1ns / 1ps
`default_nettype none
package vds_pkg;

    localparam int ELEM_W  = 16;
    localparam int ACC_W   = 48;
    localparam int SCORE_W = 31;
    localparam int MUL_W   = 25;
    localparam int PROD_W  = 2 * MUL_W;
    localparam int ROOT_W  = 24;
    localparam int QUOT_W  = 17;
    localparam int STEP_W  = 6;
    localparam int PADDR_W = 3;

    localparam logic [STEP_W-1:0] MAC_LAST  = 6'd4;
    localparam logic [STEP_W-1:0] ROOT_LAST = 6'd31;
    localparam logic [STEP_W-1:0] DIV_LAST  = 6'd63;

    localparam logic [63:0] SQRT_BIT0 = 64'h4000_0000_0000_0000;

    localparam logic [SCORE_W-1:0] SCORE_MAX = 31'd1073741823;
    localparam logic [QUOT_W-1:0]  ONE_Q16   = 17'd65536;

    localparam logic [ACC_W-1:0] SUM_MAX_U = {ACC_W{1'b1}};
    localparam logic [ACC_W-1:0] DOT_MAX   = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic [ACC_W-1:0] DOT_MIN   = {1'b1, {(ACC_W-1){1'b0}}};

    // register index within the configuration space
    localparam logic REG_SCORE_MODE = 1'b0;

    localparam logic MODE_L2     = 1'b0;
    localparam logic MODE_COSINE = 1'b1;

    typedef enum logic [7:0] {
        ST_IDLE    = 8'b0000_0001,
        ST_MAC     = 8'b0000_0010,
        ST_ROOT_D  = 8'b0000_0100,
        ST_ROOT_Q  = 8'b0000_1000,
        ST_ROOT_T  = 8'b0001_0000,
        ST_MUL_DEN = 8'b0010_0000,
        ST_DIV     = 8'b0100_0000,
        ST_DONE    = 8'b1000_0000
    } state_t;

endpackage
`default_nettype wire

@@ hdl/vector_distance_score.sv @@
// streaming l2 distance / cosine similarity scorer, top level
//
//  channel   dir   handshake                 contents
//  s_*       in    s_tvalid / s_tready       query, target element pair, tlast = last pair
//  m_*       out   m_tvalid / m_tready       score, l2 Q22.8 / cosine signed Q15.16
//  apb       in    psel, penable, pready     score_mode at address 0
//
//  a pair passes idle, then the accumulate steps on the shared multiplier and adder;
//  a last pair then adds one 32-step root in l2 mode, and in cosine mode two 32-step roots,
//  one multiply of the roots and one 64-step divide
//  s_tready is high only in idle; a result that waits in the output register
//  holds the next score in its final state until m_tready takes the transfer
//  synchronous active-low reset clears the sums, the mode and the output valid
`timescale 1ns / 1ps
`default_nettype none
module vector_distance_score (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // s_tdata: query_element [15:0], target_element [31:16]
    input  wire logic [31:0]                   s_tdata,
    input  wire logic                          s_tlast,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // m_tdata: score [30:0], zero [31]
    output logic [31:0]                        m_tdata,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [vds_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [31:0]                   pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);

    vds_pkg::state_t state_reg, state_next;
    logic [vds_pkg::STEP_W-1:0] step_reg, step_next;
    logic mode_reg, mode_next;
    logic m_tvalid_reg, m_tvalid_next;

    logic        [vds_pkg::ACC_W-1:0] diff_sum_reg, diff_sum_next;
    logic        [vds_pkg::ACC_W-1:0] dot_sum_reg, dot_sum_next;
    logic        [vds_pkg::ACC_W-1:0] qnorm_reg, qnorm_next;
    logic        [vds_pkg::ACC_W-1:0] tnorm_reg, tnorm_next;

    // payload
    logic signed [vds_pkg::ELEM_W-1:0]  q_reg, q_next;
    logic signed [vds_pkg::ELEM_W-1:0]  t_reg, t_next;
    logic                               last_reg, last_next;
    logic signed [vds_pkg::PROD_W-1:0]  prod_reg, prod_next;
    logic        [63:0]                 work_reg, work_next;
    logic        [63:0]                 res_reg, res_next;
    logic        [63:0]                 bit_reg, bit_next;
    logic        [vds_pkg::ACC_W-1:0]   rem_reg, rem_next;
    logic        [vds_pkg::QUOT_W-1:0]  quot_reg, quot_next;
    logic                               ovf_reg, ovf_next;
    logic        [vds_pkg::ROOT_W-1:0]  rq_reg, rq_next;
    logic        [vds_pkg::ROOT_W-1:0]  rt_reg, rt_next;
    logic        [vds_pkg::SCORE_W-1:0] score_reg, score_next;
    logic        [vds_pkg::SCORE_W-1:0] out_score_reg, out_score_next;

    // shared units
    logic signed [vds_pkg::ELEM_W:0]    diff_qt;
    logic signed [vds_pkg::MUL_W-1:0]   mul_a, mul_b;
    logic signed [vds_pkg::PROD_W-1:0]  mul_p;
    logic signed [vds_pkg::PROD_W-1:0]  add_a, add_sum;
    logic        [vds_pkg::ACC_W-1:0]   sat_u, sat_s;
    logic        [63:0]                 sub_a, sub_b;
    logic        [64:0]                 sub_full;
    logic                               sub_ge;
    logic        [vds_pkg::ACC_W:0]     rem_sh;
    logic        [vds_pkg::ACC_W-1:0]   den;
    logic        [vds_pkg::ACC_W-1:0]   dot_mag;
    logic        [vds_pkg::QUOT_W-1:0]  cos_mag;
    logic                               cfg_wr;
    logic                               out_free;

    assign s_tready = (state_reg == vds_pkg::ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, out_score_reg};
    assign pready   = 1'b1;
    assign prdata   = (paddr[vds_pkg::PADDR_W-1] == vds_pkg::REG_SCORE_MODE)
                      ? {31'd0, mode_reg} : 32'd0;
    assign cfg_wr   = psel && penable && pwrite && pready
                      && (paddr[vds_pkg::PADDR_W-1] == vds_pkg::REG_SCORE_MODE);
    assign out_free = !m_tvalid_reg || m_tready;

    assign diff_qt = {q_reg[vds_pkg::ELEM_W-1], q_reg} - {t_reg[vds_pkg::ELEM_W-1], t_reg};
    assign den     = prod_reg[vds_pkg::ACC_W-1:0];
    assign dot_mag = dot_sum_reg[vds_pkg::ACC_W-1] ? (vds_pkg::ACC_W'(0) - dot_sum_reg)
                                                   : dot_sum_reg;

    // multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        if (state_reg == vds_pkg::ST_MUL_DEN) begin
            mul_a = {1'b0, rq_reg};
            mul_b = {1'b0, rt_reg};
        end else begin
            case (step_reg)
                6'd0: begin
                    mul_a = {{8{diff_qt[vds_pkg::ELEM_W]}}, diff_qt};
                    mul_b = {{8{diff_qt[vds_pkg::ELEM_W]}}, diff_qt};
                end
                6'd1: begin
                    mul_a = {{9{q_reg[vds_pkg::ELEM_W-1]}}, q_reg};
                    mul_b = {{9{t_reg[vds_pkg::ELEM_W-1]}}, t_reg};
                end
                6'd2: begin
                    mul_a = {{9{q_reg[vds_pkg::ELEM_W-1]}}, q_reg};
                    mul_b = {{9{q_reg[vds_pkg::ELEM_W-1]}}, q_reg};
                end
                default: begin
                    mul_a = {{9{t_reg[vds_pkg::ELEM_W-1]}}, t_reg};
                    mul_b = {{9{t_reg[vds_pkg::ELEM_W-1]}}, t_reg};
                end
            endcase
        end
    end

    assign mul_p = mul_a * mul_b;

    // saturating accumulate of the registered product
    always_comb begin
        case (step_reg)
            6'd1:    add_a = {2'b00, diff_sum_reg};
            6'd2:    add_a = {{2{dot_sum_reg[vds_pkg::ACC_W-1]}}, dot_sum_reg};
            6'd3:    add_a = {2'b00, qnorm_reg};
            default: add_a = {2'b00, tnorm_reg};
        endcase
    end

    assign add_sum = add_a + prod_reg;
    assign sat_u   = (add_sum[vds_pkg::PROD_W-1:vds_pkg::ACC_W] != 2'b00)
                     ? vds_pkg::SUM_MAX_U : add_sum[vds_pkg::ACC_W-1:0];

    always_comb begin
        if (add_sum[vds_pkg::PROD_W-1:vds_pkg::ACC_W-1] == 3'b000
                || add_sum[vds_pkg::PROD_W-1:vds_pkg::ACC_W-1] == 3'b111) begin
            sat_s = add_sum[vds_pkg::ACC_W-1:0];
        end else if (add_sum[vds_pkg::PROD_W-1]) begin
            sat_s = vds_pkg::DOT_MIN;
        end else begin
            sat_s = vds_pkg::DOT_MAX;
        end
    end

    // shared compare-subtract for root and divide steps
    assign rem_sh = {rem_reg, work_reg[63]};

    always_comb begin
        if (state_reg == vds_pkg::ST_DIV) begin
            sub_a = {15'd0, rem_sh};
            sub_b = {16'd0, den};
        end else begin
            sub_a = work_reg;
            sub_b = res_reg | bit_reg;
        end
    end

    assign sub_full = {1'b0, sub_a} - {1'b0, sub_b};
    assign sub_ge   = !sub_full[64];

    always_comb begin
        state_next     = state_reg;
        step_next      = step_reg;
        mode_next      = mode_reg;
        m_tvalid_next  = m_tvalid_reg;
        diff_sum_next  = diff_sum_reg;
        dot_sum_next   = dot_sum_reg;
        qnorm_next     = qnorm_reg;
        tnorm_next     = tnorm_reg;
        q_next         = q_reg;
        t_next         = t_reg;
        last_next      = last_reg;
        prod_next      = prod_reg;
        work_next      = work_reg;
        res_next       = res_reg;
        bit_next       = bit_reg;
        rem_next       = rem_reg;
        quot_next      = quot_reg;
        ovf_next       = ovf_reg;
        rq_next        = rq_reg;
        rt_next        = rt_reg;
        score_next     = score_reg;
        out_score_next = out_score_reg;
        cos_mag        = '0;

        if (cfg_wr) begin
            mode_next = pwdata[0];
        end
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        // one root step, used by all three root states
        if (state_reg == vds_pkg::ST_ROOT_D || state_reg == vds_pkg::ST_ROOT_Q
                || state_reg == vds_pkg::ST_ROOT_T) begin
            work_next = sub_ge ? sub_full[63:0] : work_reg;
            res_next  = sub_ge ? ((res_reg >> 1) | bit_reg) : (res_reg >> 1);
            bit_next  = bit_reg >> 2;
            step_next = step_reg + 6'd1;
        end

        unique case (state_reg)
            vds_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    q_next     = s_tdata[15:0];
                    t_next     = s_tdata[31:16];
                    last_next  = s_tlast;
                    step_next  = '0;
                    state_next = vds_pkg::ST_MAC;
                end
            end
            vds_pkg::ST_MAC: begin
                if (step_reg != vds_pkg::MAC_LAST) begin
                    prod_next = mul_p;
                end
                case (step_reg)
                    6'd1:    diff_sum_next = sat_u;
                    6'd2:    dot_sum_next  = sat_s;
                    6'd3:    qnorm_next    = sat_u;
                    6'd4:    tnorm_next    = sat_u;
                    default: ;
                endcase
                step_next = step_reg + 6'd1;
                if (step_reg == vds_pkg::MAC_LAST) begin
                    step_next = '0;
                    res_next  = '0;
                    bit_next  = vds_pkg::SQRT_BIT0;
                    if (!last_reg) begin
                        state_next = vds_pkg::ST_IDLE;
                    end else if (mode_reg == vds_pkg::MODE_L2) begin
                        work_next  = {diff_sum_reg, 16'd0};
                        state_next = vds_pkg::ST_ROOT_D;
                    end else begin
                        work_next  = {16'd0, qnorm_reg};
                        state_next = vds_pkg::ST_ROOT_Q;
                    end
                end
            end
            vds_pkg::ST_ROOT_D: begin
                if (step_reg == vds_pkg::ROOT_LAST) begin
                    score_next = (res_next[63:30] != '0) ? vds_pkg::SCORE_MAX
                                                         : res_next[vds_pkg::SCORE_W-1:0];
                    state_next = vds_pkg::ST_DONE;
                end
            end
            vds_pkg::ST_ROOT_Q: begin
                if (step_reg == vds_pkg::ROOT_LAST) begin
                    rq_next    = res_next[vds_pkg::ROOT_W-1:0];
                    work_next  = {16'd0, tnorm_reg};
                    res_next   = '0;
                    bit_next   = vds_pkg::SQRT_BIT0;
                    step_next  = '0;
                    state_next = vds_pkg::ST_ROOT_T;
                end
            end
            vds_pkg::ST_ROOT_T: begin
                if (step_reg == vds_pkg::ROOT_LAST) begin
                    rt_next    = res_next[vds_pkg::ROOT_W-1:0];
                    state_next = vds_pkg::ST_MUL_DEN;
                end
            end
            vds_pkg::ST_MUL_DEN: begin
                prod_next  = mul_p;
                work_next  = {dot_mag, 16'd0};
                rem_next   = '0;
                quot_next  = '0;
                ovf_next   = 1'b0;
                step_next  = '0;
                state_next = vds_pkg::ST_DIV;
            end
            vds_pkg::ST_DIV: begin
                work_next = work_reg << 1;
                rem_next  = sub_ge ? sub_full[vds_pkg::ACC_W-1:0]
                                   : rem_sh[vds_pkg::ACC_W-1:0];
                quot_next = {quot_reg[vds_pkg::QUOT_W-2:0], sub_ge};
                // bits that leave the 17-bit window only mark overflow
                ovf_next  = ovf_reg | quot_reg[vds_pkg::QUOT_W-1];
                step_next = step_reg + 6'd1;
                if (step_reg == vds_pkg::DIV_LAST) begin
                    cos_mag = (ovf_next || quot_next > vds_pkg::ONE_Q16) ? vds_pkg::ONE_Q16
                                                                         : quot_next;
                    if (den == '0) begin
                        score_next = '0;
                    end else if (dot_sum_reg[vds_pkg::ACC_W-1]) begin
                        score_next = vds_pkg::SCORE_W'(0) - {14'd0, cos_mag};
                    end else begin
                        score_next = {14'd0, cos_mag};
                    end
                    state_next = vds_pkg::ST_DONE;
                end
            end
            vds_pkg::ST_DONE: begin
                // the output register only takes a new score when it is free
                if (out_free) begin
                    m_tvalid_next  = 1'b1;
                    out_score_next = score_reg;
                    diff_sum_next  = '0;
                    dot_sum_next   = '0;
                    qnorm_next     = '0;
                    tnorm_next     = '0;
                    state_next     = vds_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = vds_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= vds_pkg::ST_IDLE;
            step_reg     <= '0;
            mode_reg     <= vds_pkg::MODE_L2;
            m_tvalid_reg <= 1'b0;
            diff_sum_reg <= '0;
            dot_sum_reg  <= '0;
            qnorm_reg    <= '0;
            tnorm_reg    <= '0;
        end else begin
            state_reg    <= state_next;
            step_reg     <= step_next;
            mode_reg     <= mode_next;
            m_tvalid_reg <= m_tvalid_next;
            diff_sum_reg <= diff_sum_next;
            dot_sum_reg  <= dot_sum_next;
            qnorm_reg    <= qnorm_next;
            tnorm_reg    <= tnorm_next;
        end
    end

    always_ff @(posedge aclk) begin
        q_reg         <= q_next;
        t_reg         <= t_next;
        last_reg      <= last_next;
        prod_reg      <= prod_next;
        work_reg      <= work_next;
        res_reg       <= res_next;
        bit_reg       <= bit_next;
        rem_reg       <= rem_next;
        quot_reg      <= quot_next;
        ovf_reg       <= ovf_next;
        rq_reg        <= rq_next;
        rt_reg        <= rt_next;
        score_reg     <= score_next;
        out_score_reg <= out_score_next;
    end

`ifndef SYNTH
    a_valid_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == vds_pkg::ST_DONE))
        else $error("result valid raised outside the done state");

    a_sums_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> (diff_sum_reg == '0 && dot_sum_reg == '0
                                 && qnorm_reg == '0 && tnorm_reg == '0))
        else $error("sums not cleared with the score transfer");

    a_mac_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == vds_pkg::ST_MAC) |-> (step_reg <= vds_pkg::MAC_LAST))
        else $error("accumulate step counter out of range");

    a_accept_starts_mac: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == vds_pkg::ST_MAC && step_reg == '0))
        else $error("accepted pair did not start accumulation");

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("waiting score changed before its transfer");
`endif

endmodule
`default_nettype wire
